>>> rtl/core/fau_pkg.sv
// Package with widths, operation codes and the queue entry type of the fraction unit.
package fau_pkg;
  localparam int FIELD_WIDTH = 16;
  localparam int OUT_WIDTH = 2 * FIELD_WIDTH + 1;
  localparam int CNT_WIDTH = $clog2(FIELD_WIDTH + 1);

  typedef enum logic [1:0] {
    OP_MUL = 2'd0,
    OP_DIV = 2'd1,
    OP_ADD = 2'd2,
    OP_SUB = 2'd3
  } op_t;

  typedef struct packed {
    op_t                            mode;
    logic signed [FIELD_WIDTH-1:0]  num_a;
    logic [FIELD_WIDTH-1:0]         den_a;
    logic signed [FIELD_WIDTH-1:0]  num_b;
    logic [FIELD_WIDTH-1:0]         den_b;
    logic                           need_gcd;
  } job_t;
endpackage

>>> rtl/core/fau_if.sv
// Valid/ready channel interfaces for the input and result beats.
interface fau_in_if (input logic clk);
  logic                                   valid;
  logic                                   ready;
  logic [1:0]                             mode;
  logic signed [fau_pkg::FIELD_WIDTH-1:0] num_a;
  logic [fau_pkg::FIELD_WIDTH-1:0]        den_a;
  logic signed [fau_pkg::FIELD_WIDTH-1:0] num_b;
  logic [fau_pkg::FIELD_WIDTH-1:0]        den_b;
  modport source (output valid, mode, num_a, den_a, num_b, den_b, input ready);
  modport sink (input valid, mode, num_a, den_a, num_b, den_b, output ready);
endinterface

interface fau_out_if (input logic clk);
  logic                                 valid;
  logic                                 ready;
  logic signed [fau_pkg::OUT_WIDTH-1:0] res_num;
  logic signed [fau_pkg::OUT_WIDTH-1:0] res_den;
  logic                                 zero_den;
  modport source (output valid, res_num, res_den, zero_den, input ready);
  modport sink (input valid, res_num, res_den, zero_den, output ready);
endinterface

>>> rtl/core/fau_front.sv
// Front end: accepts beats, classifies them and holds them in a two-entry queue.
module fau_front (
  input  logic          clk,
  input  logic          rst_n,
  fau_in_if.sink        in_ch,
  output logic          job_valid,
  input  logic          job_ready,
  output fau_pkg::job_t job
);
  import fau_pkg::*;

  job_t       q_r [2];
  job_t       q_nxt;
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready;
  assign job_valid = (cnt_r != 2'd0);
  assign pop = job_valid && job_ready;
  assign job = q_r[rp_r];

  always_comb begin
    q_nxt.mode = op_t'(in_ch.mode);
    q_nxt.num_a = in_ch.num_a;
    q_nxt.den_a = in_ch.den_a;
    q_nxt.num_b = in_ch.num_b;
    q_nxt.den_b = in_ch.den_b;
    q_nxt.need_gcd = in_ch.mode[1] && (in_ch.den_a != in_ch.den_b)
                     && (in_ch.den_a != '0) && (in_ch.den_b != '0);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= q_nxt;
    end
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> rtl/core/fau_back.sv
// Back end: gcd by subtraction, restoring division, multiplies and the result register.
module fau_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          job_valid,
  output logic          job_ready,
  input  fau_pkg::job_t job,
  fau_out_if.source     out_ch
);
  import fau_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_GCD  = 6'b000010,
    S_DIVB = 6'b000100,
    S_DIVA = 6'b001000,
    S_MUL  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  localparam int FW = FIELD_WIDTH;
  localparam int IDX_WIDTH = $clog2(FW);

  state_t                state_r, state_nxt;
  job_t                  job_r;
  logic [FW-1:0]         x_r, y_r;
  logic [FW-1:0]         qb_r, qa_r;
  logic [FW-1:0]         rem_r, quo_r;
  logic [CNT_WIDTH-1:0]  cnt_r;
  logic signed [OUT_WIDTH-1:0] rn_r, rd_r;
  logic                  flag_r;
  logic [FW:0]           rem_sh, rem_sub;
  logic signed [2*FW+1:0] pa, pb, pd;
  logic signed [OUT_WIDTH-1:0] rn_nxt, rd_nxt;
  logic                  flag_nxt;
  logic [FW-1:0]         dvd;
  logic [IDX_WIDTH-1:0]  bit_idx;

  assign job_ready = (state_r == S_IDLE);
  assign out_ch.valid = (state_r == S_OUT);
  assign out_ch.res_num = rn_r;
  assign out_ch.res_den = rd_r;
  assign out_ch.zero_den = flag_r;

  assign dvd = (state_r == S_DIVB) ? job_r.den_b : job_r.den_a;
  assign bit_idx = IDX_WIDTH'(cnt_r - CNT_WIDTH'(1));
  assign rem_sh = {rem_r, dvd[bit_idx]};
  assign rem_sub = rem_sh - {1'b0, x_r};

  always_comb begin
    pa = '0;
    pb = '0;
    pd = '0;
    rn_nxt = '0;
    rd_nxt = '0;
    flag_nxt = 1'b0;
    unique case (job_r.mode)
      OP_MUL: begin
        pa = (2*FW+2)'(job_r.num_a) * (2*FW+2)'(job_r.num_b);
        pd = $signed({2'b0, job_r.den_a}) * $signed({2'b0, job_r.den_b});
        rn_nxt = pa[OUT_WIDTH-1:0];
        rd_nxt = pd[OUT_WIDTH-1:0];
      end
      OP_DIV: begin
        if (job_r.num_b == '0) begin
          flag_nxt = 1'b1;
        end else begin
          pa = (2*FW+2)'(job_r.num_a) * $signed({2'b0, job_r.den_b});
          pd = $signed({2'b0, job_r.den_a}) * (2*FW+2)'(job_r.num_b);
          rn_nxt = pa[OUT_WIDTH-1:0];
          rd_nxt = pd[OUT_WIDTH-1:0];
        end
      end
      OP_ADD, OP_SUB: begin
        if (job_r.den_a == job_r.den_b) begin
          pa = (2*FW+2)'(job_r.num_a);
          pb = (2*FW+2)'(job_r.num_b);
          pd = $signed({2'b0, job_r.den_a});
        end else begin
          pa = (2*FW+2)'(job_r.num_a) * $signed({2'b0, qb_r});
          pb = (2*FW+2)'(job_r.num_b) * $signed({2'b0, qa_r});
          pd = $signed({2'b0, job_r.den_a}) * $signed({2'b0, qb_r});
        end
        rn_nxt = (job_r.mode == OP_SUB) ? OUT_WIDTH'(pa - pb) : OUT_WIDTH'(pa + pb);
        rd_nxt = pd[OUT_WIDTH-1:0];
      end
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (job_valid) state_nxt = job.need_gcd ? S_GCD : S_MUL;
      S_GCD:  if (x_r == y_r) state_nxt = S_DIVB;
      S_DIVB: if (cnt_r == CNT_WIDTH'(1)) state_nxt = S_DIVA;
      S_DIVA: if (cnt_r == CNT_WIDTH'(1)) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_OUT;
      S_OUT:  if (out_ch.ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        job_r <= job;
        x_r <= job.den_a;
        y_r <= job.den_b;
        qa_r <= job.den_a;
        qb_r <= job.den_b;
        rem_r <= '0;
        cnt_r <= CNT_WIDTH'(FW);
      end
      S_GCD: begin
        if (x_r > y_r) x_r <= x_r - y_r;
        else if (y_r > x_r) y_r <= y_r - x_r;
      end
      S_DIVB, S_DIVA: begin
        if (!rem_sub[FW]) begin
          rem_r <= rem_sub[FW-1:0];
          quo_r <= {quo_r[FW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[FW-1:0];
          quo_r <= {quo_r[FW-2:0], 1'b0};
        end
        if (cnt_r == CNT_WIDTH'(1)) begin
          cnt_r <= CNT_WIDTH'(FW);
          rem_r <= '0;
          if (state_r == S_DIVB) qb_r <= {quo_r[FW-2:0], !rem_sub[FW]};
          else qa_r <= {quo_r[FW-2:0], !rem_sub[FW]};
        end else begin
          cnt_r <= cnt_r - CNT_WIDTH'(1);
        end
      end
      S_MUL: begin
        rn_r <= rn_nxt;
        rd_r <= rd_nxt;
        flag_r <= flag_nxt;
      end
      default: ;
    endcase
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end
endmodule

>>> rtl/core/fraction_arithmetic_unit.sv
// Top level of the fraction arithmetic unit.
// The unit takes one beat on the input channel: an operation (multiply, divide,
// add, subtract) and two fractions, each a signed numerator and an unsigned
// denominator. It returns one beat on the result channel with an unreduced
// numerator and denominator, and a flag for divide by a zero numerator.
// A front end takes beats into a two-entry queue; a back end works on one at a time.
// Multiply, divide and add or subtract with equal or zero denominators go from the
// queue through the idle, multiply and output states of the back end, which takes
// no new beat until the result is taken. Add or subtract with unequal nonzero
// denominators first runs a subtractive gcd, one cycle per subtraction step (up to
// 65534 steps for 16-bit denominators), then two 16-bit restoring divisions that
// give each denominator over the gcd.
// The shared gcd and divider loop in the back end sets the throughput.
// While the receiver stalls, the result is held and the queue still accepts
// up to two more beats before in_ready falls.
// A synchronous active-low reset empties the queue and idles the back end.
module fraction_arithmetic_unit (
  input logic    clk,
  input logic    rst_n,
  fau_in_if.sink    in_ch,
  fau_out_if.source out_ch
);
  import fau_pkg::*;

  logic job_valid, job_ready;
  job_t job;

  fau_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job)
  );

  fau_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_ch    (out_ch)
  );
endmodule
